// ===== design/hct_pkg.sv =====
package hct_pkg;

  localparam int unsigned KEY_W        = 31;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned SLOT_INDEX_W = 3;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned DIGITS       = (KEY_W + DIGIT_W - 1) / DIGIT_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_FOUND     = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REM,
    CS_CHAIN,
    CS_PROBE,
    CS_FIND
  } ctrl_state_e;

  typedef struct packed {
    logic    accept;
    logic    load_home;
    logic    follow;
    logic    step_next;
    logic    store;
    logic    link;
    logic    emit;
    status_e status;
    logic    idx_pos;
  } dp_cmd_t;

  typedef struct packed {
    logic is_find;
    logic rem_done;
    logic used;
    logic link_valid;
    logic key_hit;
    logic steps_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/hct_if.sv =====
interface hct_req_if;
  import hct_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface hct_rsp_if;
  import hct_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_INDEX_W-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink (input valid, input status, input slot_index, output ready);
endinterface

// ===== design/hct_ram.sv =====
module hct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/hct_rem.sv =====
module hct_rem #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [hct_pkg::KEY_W-1:0]      key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem_o
);
  import hct_pkg::*;

  localparam int unsigned RemW = $clog2(TABLE_SLOTS);
  localparam int unsigned AccW = RemW + DIGIT_W;
  localparam int unsigned ShW  = DIGITS * DIGIT_W;
  localparam int unsigned CntW = $clog2(DIGITS);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [ShW-1:0]  sh_q;
  logic [RemW-1:0] r_q;
  logic [AccW-1:0] acc;
  logic [AccW-1:0] res;

  // One hex digit per cycle: the partial remainder stays below the table size.
  always_comb begin
    acc = {r_q, sh_q[ShW-1 -: DIGIT_W]};
    res = acc;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (acc >= AccW'(k * TABLE_SLOTS)) begin
        res = acc - AccW'(k * TABLE_SLOTS);
      end
    end
  end

  assign rem_o  = res[RemW-1:0];
  assign done_o = busy_q && (cnt_q == CntW'(DIGITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= ShW'(key_i);
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= sh_q << DIGIT_W;
      r_q  <= res[RemW-1:0];
    end
  end

endmodule

// ===== design/hct_dp.sv =====
module hct_dp #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_cmd_i,
  input  logic [hct_pkg::KEY_W-1:0]            req_key_i,
  input  logic                                 rsp_ready_i,
  input  hct_pkg::dp_cmd_t                     cmd_i,
  output hct_pkg::dp_stat_t                    stat_o,
  output logic                                 rsp_valid_o,
  output logic [hct_pkg::STATUS_W-1:0]         rsp_status_o,
  output logic [hct_pkg::SLOT_INDEX_W-1:0]     rsp_slot_index_o
);
  import hct_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_SLOTS);
  localparam int unsigned StepW = $clog2(TABLE_SLOTS + 1);

  logic                       cmd_q;
  logic [KEY_W-1:0]           key_q;
  logic [IdxW-1:0]            pos_q, pos_d;
  logic [IdxW-1:0]            tail_q, tail_d;
  logic [StepW-1:0]           steps_q, steps_d;
  logic [TABLE_SLOTS-1:0]     used_q;
  logic [TABLE_SLOTS-1:0]     lvalid_q;
  logic [IdxW-1:0]            pos_next;
  logic [IdxW-1:0]            rem;
  logic                       rem_done;
  logic [KEY_W-1:0]           rd_key;
  logic [IdxW-1:0]            rd_link;
  logic [IdxW+SLOT_INDEX_W-1:0] pos_ext;
  logic                       out_valid_q;
  status_e                    out_status_q;
  logic [SLOT_INDEX_W-1:0]    out_idx_q;

  hct_rem #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.accept),
    .key_i  (req_key_i),
    .done_o (rem_done),
    .rem_o  (rem)
  );

  // Both stores are read at the next slot, so their data matches pos_q.
  hct_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(pos_q),
    .wdata_i(key_q),
    .raddr_i(pos_d),
    .rdata_o(rd_key)
  );

  hct_ram #(
    .WIDTH(IdxW),
    .DEPTH(TABLE_SLOTS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.link),
    .waddr_i(tail_q),
    .wdata_i(pos_q),
    .raddr_i(pos_d),
    .rdata_o(rd_link)
  );

  assign pos_next = (pos_q == IdxW'(TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;
  assign pos_ext  = {{SLOT_INDEX_W{1'b0}}, pos_q};

  always_comb begin
    pos_d   = pos_q;
    tail_d  = tail_q;
    steps_d = steps_q;
    if (cmd_i.load_home) begin
      pos_d   = rem;
      tail_d  = rem;
      steps_d = '0;
    end else if (cmd_i.follow) begin
      pos_d   = rd_link;
      tail_d  = rd_link;
      steps_d = steps_q + 1'b1;
    end else if (cmd_i.step_next) begin
      pos_d   = pos_next;
      steps_d = steps_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    tail_q  <= tail_d;
    steps_q <= steps_d;
    if (cmd_i.accept) begin
      cmd_q <= req_cmd_i;
      key_q <= req_key_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_idx_q    <= cmd_i.idx_pos ? pos_ext[SLOT_INDEX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      lvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        used_q[pos_q] <= 1'b1;
      end
      if (cmd_i.link) begin
        lvalid_q[tail_q] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.is_find    = cmd_q;
  assign stat_o.rem_done   = rem_done;
  assign stat_o.used       = used_q[pos_q];
  assign stat_o.link_valid = lvalid_q[pos_q];
  assign stat_o.key_hit    = (rd_key == key_q);
  assign stat_o.steps_last = (steps_q == StepW'(TABLE_SLOTS));
  assign stat_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o      = out_valid_q;
  assign rsp_status_o     = out_status_q;
  assign rsp_slot_index_o = out_idx_q;

endmodule

// ===== design/hct_ctrl.sv =====
module hct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  hct_pkg::dp_stat_t  stat_i,
  output hct_pkg::dp_cmd_t   cmd_o
);
  import hct_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only produced when the output register can take it.
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = STATUS_INSERTED;
    case (state_q)
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CS_REM;
        end
      end
      CS_REM: begin
        if (stat_i.rem_done) begin
          cmd_o.load_home = 1'b1;
          state_d         = stat_i.is_find ? CS_FIND : CS_CHAIN;
        end
      end
      CS_CHAIN: begin
        if (!stat_i.used) begin
          if (stat_i.out_free) begin
            cmd_o.store   = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.status  = STATUS_INSERTED;
            cmd_o.idx_pos = 1'b1;
            state_d       = CS_IDLE;
          end
        end else if (stat_i.link_valid) begin
          if (stat_i.key_hit || stat_i.steps_last) begin
            if (stat_i.out_free) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = stat_i.key_hit ? STATUS_DUPLICATE : STATUS_FULL;
              state_d      = CS_IDLE;
            end
          end else begin
            cmd_o.follow = 1'b1;
          end
        end else begin
          state_d = CS_PROBE;
        end
      end
      CS_PROBE: begin
        if (!stat_i.used) begin
          if (stat_i.out_free) begin
            cmd_o.store   = 1'b1;
            cmd_o.link    = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.status  = STATUS_INSERTED;
            cmd_o.idx_pos = 1'b1;
            state_d       = CS_IDLE;
          end
        end else if (stat_i.key_hit || stat_i.steps_last) begin
          if (stat_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = stat_i.key_hit ? STATUS_DUPLICATE : STATUS_FULL;
            state_d      = CS_IDLE;
          end
        end else begin
          cmd_o.step_next = 1'b1;
        end
      end
      CS_FIND: begin
        if (stat_i.used && stat_i.key_hit) begin
          if (stat_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.status  = STATUS_FOUND;
            cmd_o.idx_pos = 1'b1;
            state_d       = CS_IDLE;
          end
        end else if (!stat_i.used || !stat_i.link_valid || stat_i.steps_last) begin
          if (stat_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = STATUS_NOT_FOUND;
            state_d      = CS_IDLE;
          end
        end else begin
          cmd_o.follow = 1'b1;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

// ===== design/coalesced_hash_table_unit.sv =====
// Channel  Role    Payload
// req      sink    cmd (0 insert, 1 find), key
// rsp      source  status, slot_index
//
// A request is accepted in the idle state, passes through the remainder unit
// (one hex digit of the key per cycle) and then visits one slot per cycle.
// An insert that leaves the chain for the linear probe passes from the chain state
// to the probe state first; the result waits while the output register is full.
// Reset clears the used and link flags at once; the key store needs no clearing.
// The result waits in an output register while the next request is accepted.
module coalesced_hash_table_unit #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  hct_req_if.sink   req,
  hct_rsp_if.source rsp
);
  import hct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  assign req.ready = ready;

  hct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hct_dp #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_cmd_i       (req.cmd),
    .req_key_i       (req.key),
    .rsp_ready_i     (rsp.ready),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rsp_valid_o     (rsp.valid),
    .rsp_status_o    (rsp.status),
    .rsp_slot_index_o(rsp.slot_index)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("Result written while the output register was still full.");

  a_store_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> !stat.used)
    else $error("Key stored into a slot that is already in use.");

  a_link_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link |-> (cmd.store && cmd.emit && (cmd.status == STATUS_INSERTED)))
    else $error("Link written without storing the key.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && ready) |=> !ready)
    else $error("Second request accepted while one is in progress.");

endmodule
